// ===== rtl/ced_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, register codes and types of the clap energy onset detector
package ced_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 8;
	localparam int SENS_W     = 16;
	localparam int SENS_FRAC  = 8;
	localparam int GAP_W      = 16;
	localparam int ENERGY_W   = 48;
	localparam int MS_W       = 32;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int HISTORY_DEPTH_DEF = 64;

	localparam logic [SENS_W-1:0] SENS_RST = SENS_W'(384);
	localparam logic [GAP_W-1:0]  GAP_RST  = GAP_W'(500);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1);

	// action codes of an input item
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSITIVITY = 2'd0,
		REG_MIN_GAP     = 2'd1,
		REG_SAMPLE_GAIN = 2'd2
	} ced_reg_t;

	// request from the pipeline to the history ring
	typedef struct packed {
		logic                push;
		logic [ENERGY_W-1:0] energy;
	} ced_hist_req_t;

endpackage

// ===== rtl/ced_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for input items and result items
interface ced_in_if import ced_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_end;

	modport source (output valid, output action, output sample, output frame_end,
		input ready);
	modport sink (input valid, input action, input sample, input frame_end,
		output ready);
endinterface

interface ced_out_if import ced_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                clap;
	logic [ENERGY_W-1:0] frame_energy;
	logic [MS_W-1:0]     elapsed_ms;

	modport source (output valid, output clap, output frame_energy, output elapsed_ms,
		input ready);
	modport sink (input valid, input clap, input frame_energy, input elapsed_ms,
		output ready);
endinterface

// ===== rtl/ced_history.sv =====
`timescale 1ns / 1ps
// ring memory of past frame energies with running sum
module ced_history import ced_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	localparam int HSUM_W = ENERGY_W + $clog2(HISTORY_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ced_hist_req_t     req,
	output logic [HSUM_W-1:0] sum
);

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

	logic [ENERGY_W-1:0] mem [HISTORY_DEPTH];
	logic [ENERGY_W-1:0] rd_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    ptr_nx;
	logic [PTR_W-1:0]    ptr_d;
	logic                full_q;
	logic [HSUM_W-1:0]   sum_q;
	logic [ENERGY_W-1:0] oldest;

	assign ptr_nx = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
	assign ptr_d  = req.push ? ptr_nx : ptr_q;
	// entries not yet written since reset read as zero
	assign oldest = full_q ? rd_q : '0;
	assign sum    = sum_q;

	// read runs one address ahead so rd_q always holds the entry at ptr_q
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[ptr_q] <= req.energy;
		end
		rd_q <= mem[ptr_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (req.push) begin
			ptr_q <= ptr_nx;
			if (ptr_q == PTR_LAST) begin
				full_q <= 1'b1;
			end
			sum_q <= sum_q - HSUM_W'(oldest) + HSUM_W'(req.energy);
		end
	end

endmodule

// ===== rtl/clap_energy_onset_detector_top.sv =====
`timescale 1ns / 1ps
// top level of the clap energy onset detector
//
//  channel   dir  handshake       payload
//  audio     in   valid/ready     action, sample, frame_end
//  report    out  valid/ready     clap, frame_energy, elapsed_ms
//  cfg       in   cfg_we only     cfg_index, cfg_data
//
// one item per cycle unless a waiting result backs the pipeline up; a frame-end result
// passes through the five-stage pipeline: gain, square, accumulate, ring update,
// partial products, then compare into the output register
// reset is asynchronous; the ring needs no clearing pass, a fill flag masks unwritten entries
// a waiting result stalls only frame-end items in the last stage, ticks and samples keep
// draining, so input stays ready until the pipeline fills behind the result
module clap_energy_onset_detector_top import ced_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ced_in_if.sink                audio,
	ced_out_if.source             report,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HSUM_W = ENERGY_W + $clog2(HISTORY_DEPTH);
	localparam int LO_W   = (HSUM_W + 1) / 2;
	localparam int HI_W   = HSUM_W - LO_W;
	localparam int PPL_W  = SENS_W + LO_W;
	localparam int PPH_W  = SENS_W + HI_W;
	localparam int RHS_W  = SENS_W + HSUM_W;
	localparam int EDP_W  = ENERGY_W + $clog2(HISTORY_DEPTH + 1);
	localparam int LHS_W  = EDP_W + SENS_FRAC;
	localparam int CMP_W  = ((RHS_W > LHS_W) ? RHS_W : LHS_W) + 1;
	localparam int PRD_W  = SAMPLE_W + GAIN_W;

	// configuration registers
	logic [SENS_W-1:0] sens_q;
	logic [GAP_W-1:0]  gap_q;
	logic [GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_RST;
			gap_q  <= GAP_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_we) begin
			case (ced_reg_t'(cfg_index))
				REG_SENSITIVITY: sens_q <= SENS_W'(cfg_data);
				REG_MIN_GAP:     gap_q  <= GAP_W'(cfg_data);
				REG_SAMPLE_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default:         ;
			endcase
		end
	end

	// pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic act_s1, act_s2, act_s3, act_s4, act_s5;
	logic fe_s1, fe_s2;
	logic [SAMPLE_W-1:0] scaled_s1;
	logic [SQ_W-1:0]     sq_s2;
	logic [ENERGY_W-1:0] energy_s3, energy_s4, energy_s5;
	logic [HSUM_W-1:0]   hsum_s4;
	logic [LHS_W-1:0]    lhs_s5;
	logic [PPL_W-1:0]    pp_lo_s5;
	logic [PPH_W-1:0]    pp_hi_s5;

	logic [ENERGY_W-1:0] acc_q;
	logic [MS_W-1:0]     ms_q;

	logic                out_valid_q;
	logic                clap_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [MS_W-1:0]     elapsed_q;

	// stage moves, back to front
	logic out_free;
	logic mv1, mv2, mv3, mv4, mv5;
	logic can1, can2, can3, can4, can5;
	logic in_acc;

	assign out_free = !out_valid_q || report.ready;
	assign mv5  = v_s5 && (act_s5 || out_free);
	assign can5 = !v_s5 || mv5;
	assign mv4  = v_s4 && can5;
	assign can4 = !v_s4 || can5;
	assign mv3  = v_s3 && can4;
	assign can3 = !v_s3 || can4;
	assign mv2  = v_s2 && can3;
	assign can2 = !v_s2 || can3;
	assign mv1  = v_s1 && can2;
	assign can1 = !v_s1 || can2;

	assign audio.ready = can1;
	assign in_acc      = audio.valid && can1;

	// stage 1: gain, product wrapped to sample width
	logic [PRD_W-1:0] prod_full;
	assign prod_full = PRD_W'($unsigned(audio.sample)) * PRD_W'(gain_q);

	// stage 2: magnitude and square
	logic [SAMPLE_W-1:0] mag;
	assign mag = scaled_s1[SAMPLE_W-1] ? (~scaled_s1 + 1'b1) : scaled_s1;

	// stage 3: saturating frame accumulation
	logic [ENERGY_W:0]   acc_sum;
	logic [ENERGY_W-1:0] acc_sat;
	assign acc_sum = {1'b0, acc_q} + (ENERGY_W + 1)'(sq_s2);
	assign acc_sat = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];

	// stage 4: ring update, sum before insertion goes on
	ced_hist_req_t     hist_req;
	logic [HSUM_W-1:0] hsum;

	assign hist_req.push   = mv3 && (act_s3 == ACT_SAMPLE);
	assign hist_req.energy = energy_s3;

	ced_history #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hist_req),
		.sum   (hsum)
	);

	// stage 5: energy * depth * 256 against sensitivity * sum as two partial products
	logic [EDP_W-1:0] e_dep;
	assign e_dep = EDP_W'(energy_s4) * EDP_W'(HISTORY_DEPTH);

	logic [RHS_W-1:0] rhs;
	logic             over;
	logic             gap_met;
	assign rhs     = (RHS_W'(pp_hi_s5) << LO_W) + RHS_W'(pp_lo_s5);
	assign over    = CMP_W'(lhs_s5) > CMP_W'(rhs);
	assign gap_met = ms_q >= MS_W'(gap_q);

	// valid bits and state that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			acc_q       <= '0;
			ms_q        <= '1;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= in_acc || (v_s1 && !mv1);
			v_s2 <= mv1 || (v_s2 && !mv2);
			// plain samples retire once accumulated
			v_s3 <= (mv2 && (act_s2 == ACT_TICK || fe_s2)) || (v_s3 && !mv3);
			v_s4 <= mv3 || (v_s4 && !mv4);
			v_s5 <= mv4 || (v_s5 && !mv5);

			if (mv2 && act_s2 == ACT_SAMPLE) begin
				acc_q <= fe_s2 ? '0 : acc_sat;
			end

			// ticks and frame decisions reach the counter in stream order
			if (mv5) begin
				if (act_s5 == ACT_TICK) begin
					if (ms_q != '1) begin
						ms_q <= ms_q + 1'b1;
					end
				end else if (over) begin
					ms_q <= '0;
				end
			end

			if (mv5 && act_s5 == ACT_SAMPLE) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1    <= audio.action;
			fe_s1     <= audio.frame_end;
			scaled_s1 <= prod_full[SAMPLE_W-1:0];
		end
		if (mv1) begin
			act_s2 <= act_s1;
			fe_s2  <= fe_s1;
			sq_s2  <= SQ_W'(mag) * SQ_W'(mag);
		end
		if (mv2) begin
			act_s3    <= act_s2;
			energy_s3 <= acc_sat;
		end
		if (mv3) begin
			act_s4    <= act_s3;
			energy_s4 <= energy_s3;
			hsum_s4   <= hsum;
		end
		if (mv4) begin
			act_s5    <= act_s4;
			energy_s5 <= energy_s4;
			lhs_s5    <= {e_dep, {SENS_FRAC{1'b0}}};
			pp_lo_s5  <= PPL_W'(sens_q) * PPL_W'(hsum_s4[LO_W-1:0]);
			pp_hi_s5  <= PPH_W'(sens_q) * PPH_W'(hsum_s4[HSUM_W-1:LO_W]);
		end
		if (mv5 && act_s5 == ACT_SAMPLE) begin
			clap_q    <= over && gap_met;
			energy_q  <= energy_s5;
			elapsed_q <= ms_q;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.clap         = clap_q;
	assign report.frame_energy = energy_q;
	assign report.elapsed_ms   = elapsed_q;

endmodule

// ===== rtl/ced_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the clap energy onset detector and their bind
module ced_checker import ced_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                out_clap,
	input logic [ENERGY_W-1:0] out_energy,
	input logic [MS_W-1:0]     out_elapsed
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_clap)
			&& $stable(out_energy) && $stable(out_elapsed))
		else $error("result changed while stalled");

	// only a waiting result can hold back input items
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a silent frame can never beat the threshold
	a_clap_energy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_clap |-> out_energy != '0)
		else $error("clap reported on zero energy");

	// a result right after a handed-over clap never shows a saturated elapsed count with zero energy
	a_fresh_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_clap |=> !(out_valid && out_elapsed == '1
			&& !out_clap && out_energy == '0 && $past(out_energy) == '0))
		else $error("inconsistent result after clap");

endmodule

bind clap_energy_onset_detector_top ced_checker u_ced_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (audio.ready),
	.out_valid  (report.valid),
	.out_ready  (report.ready),
	.out_clap   (report.clap),
	.out_energy (report.frame_energy),
	.out_elapsed(report.elapsed_ms)
);
